// ===== hw/rtl/ile_pkg.sv =====
// ile_pkg: shared types and constants for the indexed list engine
// field widths, action and status codes, controller to datapath command and status structs
// no dependencies
package ile_pkg;

    localparam int ACTION_W = 4;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT_AT    = 4'd0,
        ACT_INSERT_FIRST = 4'd1,
        ACT_INSERT_LAST  = 4'd2,
        ACT_DELETE_AT    = 4'd3,
        ACT_DELETE_FIRST = 4'd4,
        ACT_DELETE_LAST  = 4'd5,
        ACT_GET          = 4'd6,
        ACT_SEARCH       = 4'd7,
        ACT_REVERSE      = 4'd8
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        RS_HI_M1 = 3'd0,
        RS_LO_P1 = 3'd1,
        RS_LO    = 3'd2,
        RS_HI    = 3'd3,
        RS_POS   = 3'd4
    } t_rsel;

    typedef enum logic [1:0] {
        WS_HI_RDATA = 2'd0,
        WS_LO_VAL   = 2'd1,
        WS_LO_RDATA = 2'd2,
        WS_HI_TMP   = 2'd3
    } t_wsel;

    typedef struct packed {
        logic    load;
        logic    ptr_init;
        logic    rd_en;
        t_rsel   rd_sel;
        logic    wr_en;
        t_wsel   wr_sel;
        logic    tmp_load;
        logic    lo_inc;
        logic    hi_dec;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    out_load;
        t_status res_status;
        logic    res_rd;
        logic    res_idx;
    } t_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic                full;
        logic                empty;
        logic                ins_bad;
        logic                del_bad;
        logic                get_bad;
        logic                more;
        logic                match;
    } t_stat;

endpackage

// ===== hw/rtl/ile_if.sv =====
// ile_in_if / ile_out_if: valid-ready channels of the indexed list engine
// depends on ile_pkg for field widths
interface ile_in_if;
    logic                                valid;
    logic                                ready;
    logic        [ile_pkg::ACTION_W-1:0] action;
    logic        [ile_pkg::POS_W-1:0]    position;
    logic signed [ile_pkg::VALUE_W-1:0]  value;

    modport source (output valid, action, position, value, input ready);
    modport sink   (input valid, action, position, value, output ready);
endinterface

interface ile_out_if;
    logic                                valid;
    logic                                ready;
    logic        [ile_pkg::STATUS_W-1:0] status;
    logic signed [ile_pkg::VALUE_W-1:0]  read_value;
    logic        [ile_pkg::INDEX_W-1:0]  found_index;
    logic        [ile_pkg::COUNT_W-1:0]  element_count;

    modport source (output valid, status, read_value, found_index, element_count, input ready);
    modport sink   (input valid, status, read_value, found_index, element_count, output ready);
endinterface

// ===== hw/rtl/ile_dpath.sv =====
// ile_dpath: element store, count, walk pointers and result register
// depends on ile_pkg; driven by ile_ctrl through t_cmd, reports through t_stat
module ile_dpath #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic        [ile_pkg::ACTION_W-1:0] i_action,
    input  logic        [ile_pkg::POS_W-1:0]    i_position,
    input  logic signed [ile_pkg::VALUE_W-1:0]  i_value,
    input  ile_pkg::t_cmd                       i_cmd,
    output ile_pkg::t_stat                      o_stat,
    output logic        [ile_pkg::STATUS_W-1:0] o_status,
    output logic signed [ile_pkg::VALUE_W-1:0]  o_read_value,
    output logic        [ile_pkg::INDEX_W-1:0]  o_found_index,
    output logic        [ile_pkg::COUNT_W-1:0]  o_element_count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (CW > ile_pkg::COUNT_W) ? CW : ile_pkg::COUNT_W;

    logic        [ile_pkg::VALUE_W-1:0]  r_mem [CAPACITY];
    logic        [ile_pkg::VALUE_W-1:0]  r_rdata;
    logic        [ile_pkg::VALUE_W-1:0]  r_tmp;
    logic        [ile_pkg::ACTION_W-1:0] r_act;
    logic        [ile_pkg::POS_W-1:0]    r_pos;
    logic        [ile_pkg::VALUE_W-1:0]  r_val;
    logic        [KW-1:0]                r_count;
    logic        [KW-1:0]                r_lo;
    logic        [KW-1:0]                r_hi;

    logic        [KW-1:0]                w_pos;
    logic        [KW-1:0]                w_at_ins;
    logic        [KW-1:0]                w_at_del;
    logic        [KW-1:0]                w_hi_m1;
    logic        [KW-1:0]                w_lo_p1;
    logic        [KW-1:0]                w_cnt_m1;
    logic        [AW-1:0]                w_ra;
    logic        [AW-1:0]                w_wa;
    logic        [ile_pkg::VALUE_W-1:0]  w_wd;

    assign w_pos    = {{(KW - ile_pkg::POS_W){1'b0}}, r_pos};
    assign w_hi_m1  = r_hi - KW'(1);
    assign w_lo_p1  = r_lo + KW'(1);
    assign w_cnt_m1 = r_count - KW'(1);

    always_comb begin
        case (r_act)
            ile_pkg::ACT_INSERT_AT:    w_at_ins = w_pos;
            ile_pkg::ACT_INSERT_FIRST: w_at_ins = '0;
            default:                   w_at_ins = r_count;
        endcase
        case (r_act)
            ile_pkg::ACT_DELETE_AT:    w_at_del = w_pos;
            ile_pkg::ACT_DELETE_FIRST: w_at_del = '0;
            default:                   w_at_del = w_cnt_m1;
        endcase
    end

    always_comb begin
        o_stat.act     = r_act;
        o_stat.full    = (r_count >= KW'(CAPACITY));
        o_stat.empty   = (r_count == '0);
        o_stat.ins_bad = (w_at_ins > r_count);
        o_stat.del_bad = (w_at_del >= r_count);
        o_stat.get_bad = (w_pos >= r_count);
        o_stat.more    = (r_lo < r_hi);
        o_stat.match   = (r_rdata == r_val);
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            ile_pkg::RS_HI_M1: w_ra = w_hi_m1[AW-1:0];
            ile_pkg::RS_LO_P1: w_ra = w_lo_p1[AW-1:0];
            ile_pkg::RS_LO:    w_ra = r_lo[AW-1:0];
            ile_pkg::RS_HI:    w_ra = r_hi[AW-1:0];
            ile_pkg::RS_POS:   w_ra = w_pos[AW-1:0];
            default:           w_ra = r_lo[AW-1:0];
        endcase
        unique case (i_cmd.wr_sel)
            ile_pkg::WS_HI_RDATA: begin
                w_wa = r_hi[AW-1:0];
                w_wd = r_rdata;
            end
            ile_pkg::WS_LO_VAL: begin
                w_wa = r_lo[AW-1:0];
                w_wd = r_val;
            end
            ile_pkg::WS_LO_RDATA: begin
                w_wa = r_lo[AW-1:0];
                w_wd = r_rdata;
            end
            ile_pkg::WS_HI_TMP: begin
                w_wa = r_hi[AW-1:0];
                w_wd = r_tmp;
            end
            default: begin
                w_wa = r_lo[AW-1:0];
                w_wd = r_rdata;
            end
        endcase
    end

    // single write, single registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (i_cmd.tmp_load) begin
            r_tmp <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ptr_init) begin
            case (r_act) inside
                ile_pkg::ACT_INSERT_AT, ile_pkg::ACT_INSERT_FIRST,
                ile_pkg::ACT_INSERT_LAST: begin
                    r_lo <= w_at_ins;
                    r_hi <= r_count;
                end
                ile_pkg::ACT_DELETE_AT, ile_pkg::ACT_DELETE_FIRST,
                ile_pkg::ACT_DELETE_LAST: begin
                    r_lo <= w_at_del;
                    r_hi <= w_cnt_m1;
                end
                ile_pkg::ACT_SEARCH: begin
                    r_lo <= '0;
                    r_hi <= r_count;
                end
                ile_pkg::ACT_REVERSE: begin
                    r_lo <= '0;
                    r_hi <= (r_count == '0) ? '0 : w_cnt_m1;
                end
                default: begin
                    r_lo <= r_lo;
                    r_hi <= r_hi;
                end
            endcase
        end else begin
            if (i_cmd.lo_inc) begin
                r_lo <= w_lo_p1;
            end
            if (i_cmd.hi_dec) begin
                r_hi <= w_hi_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + KW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= w_cnt_m1;
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status        <= i_cmd.res_status;
            o_read_value    <= i_cmd.res_rd ? r_rdata : '0;
            o_found_index   <= i_cmd.res_idx ? r_lo[ile_pkg::INDEX_W-1:0] : '0;
            o_element_count <= r_count[ile_pkg::COUNT_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/ile_ctrl.sv =====
// ile_ctrl: sequencer for the indexed list engine
// depends on ile_pkg; commands ile_dpath through t_cmd, reads t_stat back
module ile_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ile_pkg::t_cmd  o_cmd,
    input  ile_pkg::t_stat i_stat
);
    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_DECODE    = 14'b00000000000010,
        S_INS_LOOP  = 14'b00000000000100,
        S_INS_WR    = 14'b00000000001000,
        S_DEL_LOOP  = 14'b00000000010000,
        S_DEL_WR    = 14'b00000000100000,
        S_GET_RD    = 14'b00000001000000,
        S_SRCH_LOOP = 14'b00000010000000,
        S_SRCH_CMP  = 14'b00000100000000,
        S_REV_LOOP  = 14'b00001000000000,
        S_REV_RD_HI = 14'b00010000000000,
        S_REV_WR_LO = 14'b00100000000000,
        S_REV_WR_HI = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    ile_pkg::t_status r_status;
    ile_pkg::t_status n_status;
    logic             r_res_rd;
    logic             n_res_rd;
    logic             r_res_idx;
    logic             n_res_idx;
    logic             r_out_valid;
    logic             n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_res_rd    = r_res_rd;
        n_res_idx   = r_res_idx;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;

        o_cmd            = '0;
        o_cmd.rd_sel     = ile_pkg::RS_LO;
        o_cmd.wr_sel     = ile_pkg::WS_LO_RDATA;
        o_cmd.res_status = r_status;
        o_cmd.res_rd     = r_res_rd;
        o_cmd.res_idx    = r_res_idx;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status  = ile_pkg::ST_OK;
                n_res_rd  = 1'b0;
                n_res_idx = 1'b0;
                case (i_stat.act) inside
                    ile_pkg::ACT_INSERT_AT, ile_pkg::ACT_INSERT_FIRST,
                    ile_pkg::ACT_INSERT_LAST: begin
                        if (i_stat.full) begin
                            n_status = ile_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else if (i_stat.ins_bad) begin
                            n_status = ile_pkg::ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.ptr_init = 1'b1;
                            n_state        = S_INS_LOOP;
                        end
                    end
                    ile_pkg::ACT_DELETE_AT, ile_pkg::ACT_DELETE_FIRST,
                    ile_pkg::ACT_DELETE_LAST: begin
                        if (i_stat.empty) begin
                            n_status = ile_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end else if (i_stat.del_bad) begin
                            n_status = ile_pkg::ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.ptr_init = 1'b1;
                            n_state        = S_DEL_LOOP;
                        end
                    end
                    ile_pkg::ACT_GET: begin
                        if (i_stat.get_bad) begin
                            n_status = ile_pkg::ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_GET_RD;
                        end
                    end
                    ile_pkg::ACT_SEARCH: begin
                        n_status       = ile_pkg::ST_NOTFOUND;
                        o_cmd.ptr_init = 1'b1;
                        n_state        = S_SRCH_LOOP;
                    end
                    ile_pkg::ACT_REVERSE: begin
                        o_cmd.ptr_init = 1'b1;
                        n_state        = S_REV_LOOP;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INS_LOOP: begin
                if (i_stat.more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ile_pkg::RS_HI_M1;
                    n_state      = S_INS_WR;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = ile_pkg::WS_LO_VAL;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = ile_pkg::WS_HI_RDATA;
                o_cmd.hi_dec = 1'b1;
                n_state      = S_INS_LOOP;
            end
            S_DEL_LOOP: begin
                if (i_stat.more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ile_pkg::RS_LO_P1;
                    n_state      = S_DEL_WR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = ile_pkg::WS_LO_RDATA;
                o_cmd.lo_inc = 1'b1;
                n_state      = S_DEL_LOOP;
            end
            S_GET_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ile_pkg::RS_POS;
                n_res_rd     = 1'b1;
                n_state      = S_DONE;
            end
            S_SRCH_LOOP: begin
                if (i_stat.more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ile_pkg::RS_LO;
                    n_state      = S_SRCH_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.match) begin
                    n_status  = ile_pkg::ST_OK;
                    n_res_idx = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.lo_inc = 1'b1;
                    n_state      = S_SRCH_LOOP;
                end
            end
            S_REV_LOOP: begin
                if (i_stat.more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ile_pkg::RS_LO;
                    n_state      = S_REV_RD_HI;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REV_RD_HI: begin
                o_cmd.tmp_load = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = ile_pkg::RS_HI;
                n_state        = S_REV_WR_LO;
            end
            S_REV_WR_LO: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = ile_pkg::WS_LO_RDATA;
                n_state      = S_REV_WR_HI;
            end
            S_REV_WR_HI: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = ile_pkg::WS_HI_TMP;
                o_cmd.lo_inc = 1'b1;
                o_cmd.hi_dec = 1'b1;
                n_state      = S_REV_LOOP;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ile_pkg::ST_OK;
            r_res_rd    <= 1'b0;
            r_res_idx   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_res_rd    <= n_res_rd;
            r_res_idx   <= n_res_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/indexed_list_engine.sv =====
// indexed_list_engine: ordered list of signed 32-bit values with insert, delete, get,
// search and reverse; depends on ile_pkg, ile_if, ile_ctrl and ile_dpath
//
//   channel  dir  payload                                          beat when
//   i_in     in   action, position, value                          valid && ready
//   o_out    out  status, read_value, found_index, element_count   valid && ready
//
// one item at a time through the single-port element store: insert/delete shift each
// entry between the position and the end, search inspects entries in order until a
// match, reverse swaps pairs from both ends inward; the next item is taken while a
// result beat waits, and a finished item holds in its done state until that earlier
// beat leaves
// synchronous active-low reset clears the count; store contents are not cleared
module indexed_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ile_in_if.sink    i_in,
    ile_out_if.source o_out
);
    ile_pkg::t_cmd  w_cmd;
    ile_pkg::t_stat w_stat;
    logic           w_in_ready;
    logic           w_out_valid;

    ile_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    ile_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_action        (i_in.action),
        .i_position      (i_in.position),
        .i_value         (i_in.value),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_status        (o_out.status),
        .o_read_value    (o_out.read_value),
        .o_found_index   (o_out.found_index),
        .o_element_count (o_out.element_count)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule
